[design/tgc_pkg.sv]
// shared types, codes and constants for the touch gesture classifier
package tgc_pkg;

   // field widths
   localparam int RawWidth   = 22;
   localparam int TimeWidth  = 32;
   localparam int MsWidth    = 16;
   localparam int CodeWidth  = 3;
   localparam int MaxEvents  = 3;
   localparam int CountWidth = 2;

   // request and response word widths
   localparam int ReqDataWidth = 104;
   localparam int RspDataWidth = 8;

   // configuration port
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 22;

   localparam logic [CsrIndexWidth-1:0] RegUpThreshold     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegDownThreshold   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegCenterThreshold = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegLongPressMs     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegDoubleTapMs     = 3'd4;

   // register reset values
   localparam logic [MsWidth-1:0] LongPressMsReset = 16'd3000;
   localparam logic [MsWidth-1:0] DoubleTapMsReset = 16'd400;

   // event codes
   localparam logic [CodeWidth-1:0] EvUp     = 3'd0;
   localparam logic [CodeWidth-1:0] EvDown   = 3'd1;
   localparam logic [CodeWidth-1:0] EvLong   = 3'd2;
   localparam logic [CodeWidth-1:0] EvDouble = 3'd3;
   localparam logic [CodeWidth-1:0] EvShort  = 3'd4;

   // configuration seen by the classifier
   typedef struct packed {
      logic [RawWidth-1:0] up_threshold;
      logic [RawWidth-1:0] down_threshold;
      logic [RawWidth-1:0] center_threshold;
      logic [MsWidth-1:0]  hold_ms;
      logic [MsWidth-1:0]  window_ms;
   } cfg_type;

   // events caused by one sample, in emission order
   typedef struct packed {
      logic [CountWidth-1:0]                count;
      logic [MaxEvents-1:0][CodeWidth-1:0]  code;
   } bundle_type;

endpackage

[design/tgc_core.sv]
// gesture state and per-sample event classification
module tgc_core
   import tgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 advance,
   input  logic [RawWidth-1:0]  up_raw,
   input  logic [RawWidth-1:0]  center_raw,
   input  logic [RawWidth-1:0]  down_raw,
   input  logic [TimeWidth-1:0] now_ms,
   output bundle_type           bundle
);

   logic                 up_was_touched_ff,   up_was_touched_in;
   logic                 down_was_touched_ff, down_was_touched_in;
   logic                 center_held_ff,      center_held_in;
   logic                 long_fired_ff,       long_fired_in;
   logic [TimeWidth-1:0] press_start_ff,      press_start_in;
   logic [TimeWidth-1:0] release_ff,          release_in;

   logic                 vu, vd, cn;
   logic                 up_ev, down_ev, long_ev, dbl_ev, short_ev;
   logic                 start, lf, tap, rel_pend;
   logic [TimeWidth-1:0] hold_diff, rel_diff, rel_mid;
   logic [TimeWidth-1:0] long_lim, dtap_lim;

   // pad touch decisions
   assign vu = up_raw > cfg.up_threshold;
   assign vd = down_raw > cfg.down_threshold;
   assign cn = center_raw > cfg.center_threshold;

   assign long_lim = {{(TimeWidth-MsWidth){1'b0}}, cfg.hold_ms};
   assign dtap_lim = {{(TimeWidth-MsWidth){1'b0}}, cfg.window_ms};

   // volume edges
   assign up_ev   = vu & ~up_was_touched_ff;
   assign down_ev = vd & ~down_was_touched_ff;

   // press start and long hold
   assign start          = cn & ~center_held_ff;
   assign press_start_in = start ? now_ms : press_start_ff;
   assign lf             = start ? 1'b0 : long_fired_ff;
   assign hold_diff      = now_ms - press_start_in;
   assign long_ev        = cn & ~lf & (hold_diff >= long_lim);
   assign long_fired_in  = lf | long_ev;

   // release, double tap and short tap
   assign tap      = ~cn & center_held_ff & ~lf;
   assign rel_pend = release_ff != '0;
   assign rel_diff = now_ms - release_ff;
   assign dbl_ev   = tap & rel_pend & (rel_diff < dtap_lim);

   always_comb begin
      if (dbl_ev) begin
         rel_mid = '0;
      end else if (tap) begin
         rel_mid = now_ms;
      end else begin
         rel_mid = release_ff;
      end
   end

   // a fresh pending release has zero elapsed time
   assign short_ev = ~cn & ((~tap & rel_pend & (rel_diff >= dtap_lim)) |
                            (tap & ~dbl_ev & (now_ms != '0) & (dtap_lim == '0)));
   assign release_in = short_ev ? '0 : rel_mid;

   assign up_was_touched_in   = vu;
   assign down_was_touched_in = vd;
   assign center_held_in      = cn;

   // pack events in order: up, down, centre
   always_comb begin
      bundle.count = '0;
      bundle.code  = '0;
      if (up_ev) begin
         bundle.code[bundle.count] = EvUp;
         bundle.count              = bundle.count + 2'd1;
      end
      if (down_ev) begin
         bundle.code[bundle.count] = EvDown;
         bundle.count              = bundle.count + 2'd1;
      end
      if (long_ev) begin
         bundle.code[bundle.count] = EvLong;
         bundle.count              = bundle.count + 2'd1;
      end else if (dbl_ev) begin
         bundle.code[bundle.count] = EvDouble;
         bundle.count              = bundle.count + 2'd1;
      end else if (short_ev) begin
         bundle.code[bundle.count] = EvShort;
         bundle.count              = bundle.count + 2'd1;
      end
   end

   // state update when the sample leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         up_was_touched_ff   <= 1'b0;
         down_was_touched_ff <= 1'b0;
         center_held_ff      <= 1'b0;
         long_fired_ff       <= 1'b0;
         press_start_ff      <= '0;
         release_ff          <= '0;
      end else if (advance) begin
         up_was_touched_ff   <= up_was_touched_in;
         down_was_touched_ff <= down_was_touched_in;
         center_held_ff      <= center_held_in;
         long_fired_ff       <= long_fired_in;
         press_start_ff      <= press_start_in;
         release_ff          <= release_in;
      end
   end

endmodule

[design/tgc_out.sv]
// result register that hands out a sample's events one word at a time
module tgc_out
   import tgc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  bundle_type              bundle,
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tlast
);

   logic                  valid_ff,  valid_in;
   bundle_type            bundle_ff, bundle_in;
   logic [CountWidth-1:0] idx_ff,    idx_in;
   logic                  last, take;

   assign last     = idx_ff == (bundle_ff.count - 2'd1);
   assign take     = valid_ff & rsp_tready;
   assign can_load = ~valid_ff | (take & last);

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {{(RspDataWidth-CodeWidth){1'b0}}, bundle_ff.code[idx_ff]};

   // next bundle, word pointer and valid
   always_comb begin
      valid_in  = valid_ff;
      bundle_in = bundle_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = 1'b1;
         bundle_in = bundle;
         idx_in    = '0;
      end else if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

[design/touch_gesture_classifier.sv]
// top level of the touch gesture classifier
//
// Takes one poll sample per req word: three raw pad readings and a
// millisecond timestamp. For each sample it returns zero to three rsp
// words, each carrying one event code, in the order volume up, volume
// down, then at most one centre event (long, double or short). rsp_tlast
// marks the final event of a sample; a sample that causes no event yields
// no rsp word at all.
// The first event of a sample passes the input register, then the result
// register, before it is offered on rsp; a stall of the result register
// can hold it in the input register in between.
// Takes one sample per cycle while samples cause at most one event and
// rsp_tready stays high; a sample with more events holds the result register
// until its last word is taken, as it hands out one word per cycle while rsp_tready is high.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more sample before req_tready drops.
// Reset (synchronous, active high) clears the gesture state and both
// registers, sets the thresholds to zero, the long-press time to 3000 ms
// and the double-tap window to 400 ms. The csr port writes one register
// per cycle in which csr_we is high; write it only while the block is idle.
module touch_gesture_classifier
   import tgc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // csr write port
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   // sample input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,   // up_raw, center_raw, down_raw, now_ms
   // event output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // event_code
   output logic                     rsp_tlast    // last_event
);

   cfg_type              cfg_ff;
   logic                 inp_valid_ff, inp_valid_in;
   logic [RawWidth-1:0]  up_raw_ff, center_raw_ff, down_raw_ff;
   logic [TimeWidth-1:0] now_ff;
   logic                 can_load, advance, accept;
   bundle_type           bundle;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_threshold     <= '0;
         cfg_ff.down_threshold   <= '0;
         cfg_ff.center_threshold <= '0;
         cfg_ff.hold_ms          <= LongPressMsReset;
         cfg_ff.window_ms        <= DoubleTapMsReset;
      end else if (csr_we) begin
         case (csr_index)
            RegUpThreshold:     cfg_ff.up_threshold     <= csr_wdata;
            RegDownThreshold:   cfg_ff.down_threshold   <= csr_wdata;
            RegCenterThreshold: cfg_ff.center_threshold <= csr_wdata;
            RegLongPressMs:     cfg_ff.hold_ms          <= csr_wdata[MsWidth-1:0];
            RegDoubleTapMs:     cfg_ff.window_ms        <= csr_wdata[MsWidth-1:0];
            default: ;
         endcase
      end
   end

   // input register handshake
   assign advance      = inp_valid_ff & can_load;
   assign req_tready   = ~inp_valid_ff | can_load;
   assign accept       = req_tvalid & req_tready;
   assign inp_valid_in = accept | (inp_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         inp_valid_ff <= 1'b0;
      end else begin
         inp_valid_ff <= inp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_raw_ff     <= req_tdata[21:0];
         center_raw_ff <= req_tdata[43:22];
         down_raw_ff   <= req_tdata[65:44];
         now_ff        <= req_tdata[97:66];
      end
   end

   tgc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .advance    (advance),
      .up_raw     (up_raw_ff),
      .center_raw (center_raw_ff),
      .down_raw   (down_raw_ff),
      .now_ms     (now_ff),
      .bundle     (bundle)
   );

   tgc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance & (bundle.count != '0)),
      .bundle     (bundle),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
